// ===== hdl/bq_pkg.sv =====
// Shared constants and types for the biquad filter unit.
// No dependencies.
package bq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 48;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int STATE_FRAC  = STATE_BITS - SAMPLE_BITS - 2;
    localparam int ALIGN_SHIFT = COEF_FRAC - STATE_FRAC;
    localparam int HI_BITS     = COEF_BITS + 1;
    localparam int PROD_BITS   = HI_BITS + SAMPLE_BITS;
    localparam int ACCY_BITS   = PROD_BITS + 1;
    localparam int ACCD_BITS   = PROD_BITS + 3;
    localparam int RY_BITS     = ACCY_BITS - COEF_FRAC;
    localparam int RD_BITS     = ACCD_BITS - ALIGN_SHIFT;
    localparam int CNT_BITS    = $clog2(SAMPLE_BITS);
    localparam int ADDR_BITS   = 5;

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

    typedef enum logic [2:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_BYPASS = 3'd5
    } reg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MULX = 8'b0000_0010,
        ST_SUMY = 8'b0000_0100,
        ST_RNDY = 8'b0000_1000,
        ST_MULY = 8'b0001_0000,
        ST_SUMD = 8'b0010_0000,
        ST_RNDD = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

endpackage

// ===== hdl/biquad_tdf2_filter_unit.sv =====
// Biquad IIR section, transposed direct form II, with bit-serial multipliers.
// Depends on bq_pkg.
//
// A filtered sample makes two passes through three shift-add multipliers that take one
// multiplier bit per cycle (first the three feed-forward products of x, then the two feedback
// products of y), each pass followed by sums, rounding and saturation. A bypassed sample
// skips the multiplier passes and goes straight to the output stage. One
// sample is in work at a time; a finished result waits in the output register while the
// next sample is accepted.
module biquad_tdf2_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    input  logic        s_tuser,   // [0] clear_state
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample_out
    output logic        m_tuser,   // [0] saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [bq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB = bq_pkg::SAMPLE_BITS;
    localparam int CB = bq_pkg::COEF_BITS;
    localparam int DB = bq_pkg::STATE_BITS;
    localparam int HB = bq_pkg::HI_BITS;
    localparam int PB = bq_pkg::PROD_BITS;
    localparam int YB = bq_pkg::ACCY_BITS;
    localparam int AB = bq_pkg::ACCD_BITS;
    localparam int RYB = bq_pkg::RY_BITS;
    localparam int RDB = bq_pkg::RD_BITS;
    localparam int CW = bq_pkg::CNT_BITS;
    localparam int AL = bq_pkg::ALIGN_SHIFT;
    localparam int CF = bq_pkg::COEF_FRAC;

    bq_pkg::state_t state_reg, state_next;

    logic [CB-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic          bypass_reg;
    logic signed [DB-1:0] d1_reg, d2_reg;
    logic [SB-1:0] mult_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [HB-1:0] hi_reg [3];
    logic [SB-1:0] lo_reg [3];
    logic signed [YB-1:0] accy_reg;
    logic signed [AB-1:0] t_reg, acc1_reg, acc2_reg;
    logic signed [PB-1:0] p2_reg;
    logic signed [SB-1:0] y_reg;
    logic          sat_reg;
    logic          m_tvalid_reg;
    logic [SB-1:0] m_tdata_reg;
    logic          m_tuser_reg;

    logic          wr_en;
    logic [2:0]    reg_idx;
    logic          in_xfer, last_step, out_free;
    logic [CB-1:0] coef_sel [3];
    logic signed [HB:0] sum_w [3];
    logic signed [PB-1:0] prod_w [3];
    logic signed [YB-1:0] ry_add;
    logic signed [RYB-1:0] ry;
    logic signed [SB-1:0] y_clip;
    logic          y_ovf;
    logic signed [AB-1:0] rd1_add, rd2_add;
    logic signed [RDB-1:0] rd1, rd2;
    logic signed [DB-1:0] d1_clip, d2_clip;
    logic          d1_ovf, d2_ovf;

    localparam logic signed [RYB-1:0] Y_HI = RYB'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [RYB-1:0] Y_LO = -Y_HI - RYB'(1);
    localparam logic signed [RDB-1:0] D_HI = RDB'((64'sd1 <<< (DB - 1)) - 1);
    localparam logic signed [RDB-1:0] D_LO = -D_HI - RDB'(1);

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[4:2];
    assign s_tready  = (state_reg == bq_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid & s_tready;
    assign last_step = (cnt_reg == CW'(SB - 1));
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        unique case (reg_idx)
            bq_pkg::REG_B0:     prdata = 32'(b0_reg);
            bq_pkg::REG_B1:     prdata = 32'(b1_reg);
            bq_pkg::REG_B2:     prdata = 32'(b2_reg);
            bq_pkg::REG_A1:     prdata = 32'(a1_reg);
            bq_pkg::REG_A2:     prdata = 32'(a2_reg);
            bq_pkg::REG_BYPASS: prdata = {31'd0, bypass_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (state_reg == bq_pkg::ST_MULY) begin
            coef_sel[0] = a1_reg;
            coef_sel[1] = a2_reg;
            coef_sel[2] = '0;
        end else begin
            coef_sel[0] = b0_reg;
            coef_sel[1] = b1_reg;
            coef_sel[2] = b2_reg;
        end
    end

    // One multiplier bit per cycle; the sign bit of the multiplier has negative weight.
    for (genvar k = 0; k < 3; k++) begin : g_mul
        logic signed [HB:0] addend;
        always_comb begin
            if (!mult_reg[0]) begin
                addend = '0;
            end else if (last_step) begin
                addend = -(HB+1)'($signed(coef_sel[k]));
            end else begin
                addend = (HB+1)'($signed(coef_sel[k]));
            end
            sum_w[k]  = (HB+1)'(hi_reg[k]) + addend;
            prod_w[k] = $signed({hi_reg[k], lo_reg[k]});
        end
    end

    always_comb begin
        ry_add = accy_reg + (YB'(1) <<< (CF - 1));
        ry     = ry_add[YB-1:CF];
        y_ovf  = (ry > Y_HI) || (ry < Y_LO);
        if (ry > Y_HI) begin
            y_clip = Y_HI[SB-1:0];
        end else if (ry < Y_LO) begin
            y_clip = Y_LO[SB-1:0];
        end else begin
            y_clip = ry[SB-1:0];
        end
        rd1_add = acc1_reg + (AB'(1) <<< (AL - 1));
        rd2_add = acc2_reg + (AB'(1) <<< (AL - 1));
        rd1     = rd1_add[AB-1:AL];
        rd2     = rd2_add[AB-1:AL];
        d1_ovf  = (rd1 > D_HI) || (rd1 < D_LO);
        d2_ovf  = (rd2 > D_HI) || (rd2 < D_LO);
        if (rd1 > D_HI) begin
            d1_clip = D_HI[DB-1:0];
        end else if (rd1 < D_LO) begin
            d1_clip = D_LO[DB-1:0];
        end else begin
            d1_clip = rd1[DB-1:0];
        end
        if (rd2 > D_HI) begin
            d2_clip = D_HI[DB-1:0];
        end else if (rd2 < D_LO) begin
            d2_clip = D_LO[DB-1:0];
        end else begin
            d2_clip = rd2[DB-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = bypass_reg ? bq_pkg::ST_FIN : bq_pkg::ST_MULX;
                end
            end
            bq_pkg::ST_MULX: if (last_step) state_next = bq_pkg::ST_SUMY;
            bq_pkg::ST_SUMY: state_next = bq_pkg::ST_RNDY;
            bq_pkg::ST_RNDY: state_next = bq_pkg::ST_MULY;
            bq_pkg::ST_MULY: if (last_step) state_next = bq_pkg::ST_SUMD;
            bq_pkg::ST_SUMD: state_next = bq_pkg::ST_RNDD;
            bq_pkg::ST_RNDD: state_next = bq_pkg::ST_FIN;
            bq_pkg::ST_FIN:  if (out_free) state_next = bq_pkg::ST_IDLE;
            default:         state_next = bq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bq_pkg::ST_IDLE;
            b0_reg       <= bq_pkg::COEF_ONE;
            b1_reg       <= '0;
            b2_reg       <= '0;
            a1_reg       <= '0;
            a2_reg       <= '0;
            bypass_reg   <= 1'b1;
            d1_reg       <= '0;
            d2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                unique case (reg_idx)
                    bq_pkg::REG_B0:     b0_reg <= pwdata[CB-1:0];
                    bq_pkg::REG_B1:     b1_reg <= pwdata[CB-1:0];
                    bq_pkg::REG_B2:     b2_reg <= pwdata[CB-1:0];
                    bq_pkg::REG_A1:     a1_reg <= pwdata[CB-1:0];
                    bq_pkg::REG_A2:     a2_reg <= pwdata[CB-1:0];
                    bq_pkg::REG_BYPASS: bypass_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (in_xfer && s_tuser) begin
                d1_reg <= '0;
                d2_reg <= '0;
            end else if (state_reg == bq_pkg::ST_RNDD) begin
                d1_reg <= d1_clip;
                d2_reg <= d2_clip;
            end
            if (state_reg == bq_pkg::ST_MULX || state_reg == bq_pkg::ST_MULY) begin
                cnt_reg <= last_step ? '0 : cnt_reg + CW'(1);
            end
            if (state_reg == bq_pkg::ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bq_pkg::ST_IDLE: begin
                mult_reg <= s_tdata;
                y_reg    <= $signed(s_tdata);
                sat_reg  <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    hi_reg[k] <= '0;
                    lo_reg[k] <= '0;
                end
            end
            bq_pkg::ST_MULX, bq_pkg::ST_MULY: begin
                mult_reg <= {1'b0, mult_reg[SB-1:1]};
                for (int k = 0; k < 3; k++) begin
                    hi_reg[k] <= sum_w[k][HB:1];
                    lo_reg[k] <= {sum_w[k][0], lo_reg[k][SB-1:1]};
                end
            end
            bq_pkg::ST_SUMY: begin
                accy_reg <= YB'(prod_w[0]) + (YB'(d1_reg) <<< AL);
                t_reg    <= AB'(prod_w[1]) + (AB'(d2_reg) <<< AL);
                p2_reg   <= prod_w[2];
            end
            bq_pkg::ST_RNDY: begin
                y_reg    <= y_clip;
                sat_reg  <= y_ovf;
                mult_reg <= y_clip;
                for (int k = 0; k < 3; k++) begin
                    hi_reg[k] <= '0;
                    lo_reg[k] <= '0;
                end
            end
            bq_pkg::ST_SUMD: begin
                acc1_reg <= t_reg - AB'(prod_w[0]);
                acc2_reg <= AB'(p2_reg) - AB'(prod_w[1]);
            end
            bq_pkg::ST_RNDD: begin
                sat_reg <= sat_reg | d1_ovf | d2_ovf;
            end
            bq_pkg::ST_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= y_reg;
                    m_tuser_reg <= sat_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("second input transfer taken while a sample is in work");

    a_bypass_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && bypass_reg) |=> (state_reg == bq_pkg::ST_FIN))
        else $error("bypassed sample did not go straight to the output stage");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bq_pkg::ST_FIN && out_free) |=> m_tvalid)
        else $error("finished result was not presented");
`endif

endmodule
